FILE: hdl/aieu_pkg.sv
// Package with the shared types, codes and constants of the integer execute unit.
`default_nettype none
package aieu_pkg;
   localparam int unsigned WordWidth = 32;
   localparam int unsigned RegCount = 16;
   localparam int unsigned RegIndexWidth = 4;
   localparam int unsigned QueueDepth = 2;
   localparam logic [3:0] LinkReg = 4'd14;
   localparam logic [3:0] PcReg = 4'd15;

   typedef enum logic [1:0] {
      KIND_DATA = 2'd0,
      KIND_MUL = 2'd1,
      KIND_BRANCH = 2'd2,
      KIND_UNSUP = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type kind;
      logic [31:0] word;
   } entry_type;

   localparam logic [3:0] OpAnd = 4'd0;
   localparam logic [3:0] OpEor = 4'd1;
   localparam logic [3:0] OpSub = 4'd2;
   localparam logic [3:0] OpRsb = 4'd3;
   localparam logic [3:0] OpAdd = 4'd4;
   localparam logic [3:0] OpAdc = 4'd5;
   localparam logic [3:0] OpSbc = 4'd6;
   localparam logic [3:0] OpRsc = 4'd7;
   localparam logic [3:0] OpTst = 4'd8;
   localparam logic [3:0] OpTeq = 4'd9;
   localparam logic [3:0] OpCmp = 4'd10;
   localparam logic [3:0] OpCmn = 4'd11;
   localparam logic [3:0] OpOrr = 4'd12;
   localparam logic [3:0] OpMov = 4'd13;
   localparam logic [3:0] OpBic = 4'd14;
   localparam logic [3:0] OpMvn = 4'd15;

   localparam logic [1:0] ShLsl = 2'd0;
   localparam logic [1:0] ShLsr = 2'd1;
   localparam logic [1:0] ShAsr = 2'd2;
   localparam logic [1:0] ShRor = 2'd3;
endpackage
`default_nettype wire

FILE: hdl/aieu_decode.sv
// Front part: accepts instruction words, classifies them and queues them.
`default_nettype none
module aieu_decode #(
   parameter int unsigned QUEUE_DEPTH = aieu_pkg::QueueDepth
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_tvalid,
   output logic req_tready,
   input  wire logic [31:0] req_tdata,
   output logic q_valid,
   input  wire logic q_pop,
   output aieu_pkg::entry_type q_entry
);
   localparam int unsigned PtrWidth = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned CntWidth = $clog2(QUEUE_DEPTH + 1);

   aieu_pkg::entry_type mem_ff [QUEUE_DEPTH];
   logic [PtrWidth-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CntWidth-1:0] count_ff, count_in;
   aieu_pkg::kind_type kind;
   logic push;
   logic [2:0] cls;
   logic [3:0] op;
   logic is_mul, is_psr;

   always_comb begin
      cls = req_tdata[27:25];
      op = req_tdata[24:21];
      is_mul = (req_tdata[27:22] == 6'd0) && (req_tdata[7:4] == 4'd9);
      is_psr = (op[3:2] == 2'b10) && !req_tdata[20];
      kind = aieu_pkg::KIND_UNSUP;
      unique case (cls)
         3'd0: begin
            if (is_mul) kind = aieu_pkg::KIND_MUL;
            else if (req_tdata[7] && req_tdata[4]) kind = aieu_pkg::KIND_UNSUP;
            else if (is_psr) kind = aieu_pkg::KIND_UNSUP;
            else kind = aieu_pkg::KIND_DATA;
         end
         3'd1: kind = is_psr ? aieu_pkg::KIND_UNSUP : aieu_pkg::KIND_DATA;
         3'd5: kind = aieu_pkg::KIND_BRANCH;
         default: kind = aieu_pkg::KIND_UNSUP;
      endcase
   end

   assign req_tready = (count_ff != CntWidth'(QUEUE_DEPTH)) || q_pop;
   assign push = req_tvalid && req_tready;
   assign q_valid = (count_ff != '0);
   assign q_entry = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) wr_ptr_in = (wr_ptr_ff == PtrWidth'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      if (q_pop) rd_ptr_in = (rd_ptr_ff == PtrWidth'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      count_in = count_ff + CntWidth'(push) - CntWidth'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= '{kind: kind, word: req_tdata};
   end
endmodule
`default_nettype wire

FILE: hdl/aieu_execute.sv
// Back part: register file, flags, shifter, ALU, multiplier and branch unit.
`default_nettype none
module aieu_execute (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic q_valid,
   output logic q_pop,
   input  aieu_pkg::entry_type q_entry,
   output logic rsp_tvalid,
   input  wire logic rsp_tready,
   output logic [47:0] rsp_tdata
);
   logic [31:0] regs_ff [aieu_pkg::RegCount];
   logic [aieu_pkg::RegCount-1:0] reg_ok_ff;
   logic [3:0] flags_ff, flags_in;
   logic out_valid_ff;
   logic [47:0] out_data_ff, out_data_in;

   logic [31:0] w;
   logic fn, fz, fc, fv, cond, passed, unsup;
   logic [31:0] rn_v, rm_v, rs_v, rd_acc_v;
   logic wr_en, link;
   logic [3:0] dest;
   logic [31:0] val, b, r;
   logic sc, c, v, logical;
   logic [1:0] sty;
   logic [7:0] amt;
   logic [4:0] a5;
   logic [63:0] dbl;
   logic [32:0] sum;
   logic [31:0] opa, opb;
   logic cin, invert;
   logic [31:0] off;
   logic [31:0] mul_res;

   function automatic logic [31:0] rd_reg(input logic [31:0] v, input logic ok);
      return ok ? v : 32'd0;
   endfunction

   assign w = q_entry.word;
   assign {fn, fz, fc, fv} = flags_ff;
   assign q_pop = q_valid && (!out_valid_ff || rsp_tready);
   assign rn_v = rd_reg(regs_ff[w[19:16]], reg_ok_ff[w[19:16]]);
   assign rm_v = rd_reg(regs_ff[w[3:0]], reg_ok_ff[w[3:0]]);
   assign rs_v = rd_reg(regs_ff[w[11:8]], reg_ok_ff[w[11:8]]);
   assign rd_acc_v = rd_reg(regs_ff[w[15:12]], reg_ok_ff[w[15:12]]);

   always_comb begin
      unique case (w[31:28])
         4'd0: cond = fz;
         4'd1: cond = !fz;
         4'd2: cond = fc;
         4'd3: cond = !fc;
         4'd4: cond = fn;
         4'd5: cond = !fn;
         4'd6: cond = fv;
         4'd7: cond = !fv;
         4'd8: cond = fc && !fz;
         4'd9: cond = !fc || fz;
         4'd10: cond = fn == fv;
         4'd11: cond = fn != fv;
         4'd12: cond = !fz && (fn == fv);
         4'd13: cond = fz || (fn != fv);
         4'd14: cond = 1'b1;
         default: cond = 1'b0;
      endcase
   end

   // Barrel shifter for the second operand.
   always_comb begin
      sty = w[6:5];
      amt = 8'd0;
      a5 = 5'd0;
      b = rm_v;
      sc = fc;
      dbl = '0;
      if (w[25]) begin
         a5 = {w[11:8], 1'b0};
         dbl = {24'd0, w[7:0], 24'd0, w[7:0]} >> a5;
         b = dbl[31:0];
         sc = (a5 != 5'd0) ? b[31] : fc;
      end else begin
         amt = w[4] ? rs_v[7:0] : {3'd0, w[11:7]};
         a5 = amt[4:0];
         if (amt == 8'd0) begin
            if (w[4]) begin
               b = rm_v;
               sc = fc;
            end else begin
               unique case (sty)
                  aieu_pkg::ShLsl: begin b = rm_v; sc = fc; end
                  aieu_pkg::ShLsr: begin b = 32'd0; sc = rm_v[31]; end
                  aieu_pkg::ShAsr: begin b = {32{rm_v[31]}}; sc = rm_v[31]; end
                  default: begin b = {fc, rm_v[31:1]}; sc = rm_v[0]; end
               endcase
            end
         end else if (sty == aieu_pkg::ShRor) begin
            dbl = {rm_v, rm_v} >> a5;
            b = dbl[31:0];
            sc = (a5 == 5'd0) ? rm_v[31] : rm_v[a5 - 5'd1];
         end else if (amt < 8'd32) begin
            unique case (sty)
               aieu_pkg::ShLsl: begin b = rm_v << a5; sc = rm_v[5'd0 - a5]; end
               aieu_pkg::ShLsr: begin b = rm_v >> a5; sc = rm_v[a5 - 5'd1]; end
               default: begin
                  b = 32'($signed(rm_v) >>> a5);
                  sc = rm_v[a5 - 5'd1];
               end
            endcase
         end else if (sty == aieu_pkg::ShAsr) begin
            b = {32{rm_v[31]}};
            sc = rm_v[31];
         end else if (amt == 8'd32) begin
            b = 32'd0;
            sc = (sty == aieu_pkg::ShLsl) ? rm_v[0] : rm_v[31];
         end else begin
            b = 32'd0;
            sc = 1'b0;
         end
      end
   end

   // ALU: subtraction is addition of the inverted operand with carry in.
   always_comb begin
      opa = rn_v;
      opb = b;
      cin = 1'b0;
      invert = 1'b0;
      unique case (w[24:21])
         aieu_pkg::OpSub, aieu_pkg::OpCmp: begin invert = 1'b1; cin = 1'b1; end
         aieu_pkg::OpRsb: begin opa = b; opb = rn_v; invert = 1'b1; cin = 1'b1; end
         aieu_pkg::OpAdc: cin = fc;
         aieu_pkg::OpSbc: begin invert = 1'b1; cin = fc; end
         aieu_pkg::OpRsc: begin opa = b; opb = rn_v; invert = 1'b1; cin = fc; end
         default: ;
      endcase
      if (invert) opb = ~opb;
      sum = {1'b0, opa} + {1'b0, opb} + 33'(cin);
      logical = 1'b0;
      unique case (w[24:21])
         aieu_pkg::OpAnd, aieu_pkg::OpTst: begin r = rn_v & b; logical = 1'b1; end
         aieu_pkg::OpEor, aieu_pkg::OpTeq: begin r = rn_v ^ b; logical = 1'b1; end
         aieu_pkg::OpOrr: begin r = rn_v | b; logical = 1'b1; end
         aieu_pkg::OpMov: begin r = b; logical = 1'b1; end
         aieu_pkg::OpBic: begin r = rn_v & ~b; logical = 1'b1; end
         aieu_pkg::OpMvn: begin r = ~b; logical = 1'b1; end
         default: r = sum[31:0];
      endcase
      c = logical ? sc : sum[32];
      v = logical ? fv : ((~(opa[31] ^ opb[31])) & (opa[31] ^ sum[31]));
   end

   assign mul_res = rm_v * rs_v + (w[21] ? rd_acc_v : 32'd0);
   assign off = {{6{w[23]}}, w[23:0], 2'b00};

   always_comb begin
      unsup = (q_entry.kind == aieu_pkg::KIND_UNSUP);
      passed = !unsup && cond;
      wr_en = 1'b0;
      link = 1'b0;
      dest = 4'd0;
      val = 32'd0;
      flags_in = flags_ff;
      if (passed) begin
         unique case (q_entry.kind)
            aieu_pkg::KIND_BRANCH: begin
               link = w[24];
               wr_en = 1'b1;
               dest = aieu_pkg::PcReg;
               val = rd_reg(regs_ff[aieu_pkg::PcReg], reg_ok_ff[aieu_pkg::PcReg]) + off;
            end
            aieu_pkg::KIND_MUL: begin
               wr_en = 1'b1;
               dest = w[19:16];
               val = mul_res;
               if (w[20]) flags_in = {mul_res[31], mul_res == 32'd0, fc, fv};
            end
            default: begin
               if (w[20]) flags_in = {r[31], r == 32'd0, c, v};
               if (w[24:23] != 2'b10) begin
                  wr_en = 1'b1;
                  dest = w[15:12];
                  val = r;
               end
            end
         endcase
      end
      out_data_in = {4'd0, unsup, flags_in, link, val, dest, wr_en, passed};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         reg_ok_ff <= '0;
         flags_ff <= 4'd0;
         out_valid_ff <= 1'b0;
      end else begin
         if (q_pop) begin
            flags_ff <= flags_in;
            out_valid_ff <= 1'b1;
            if (link) reg_ok_ff[aieu_pkg::LinkReg] <= 1'b1;
            if (wr_en) reg_ok_ff[dest] <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         out_data_ff <= out_data_in;
         if (link) regs_ff[aieu_pkg::LinkReg] <=
            rd_reg(regs_ff[aieu_pkg::PcReg], reg_ok_ff[aieu_pkg::PcReg]) - 32'd4;
         if (wr_en) regs_ff[dest] <= val;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata = out_data_ff;
endmodule
`default_nettype wire

FILE: hdl/arm_integer_execute_unit.sv
// Top level of the integer execute unit: instruction queue front and execute back.
`default_nettype none
// Executes one ARM data-processing, multiply or branch instruction per clock cycle,
// back to back, while the output is not stalled; each word passes the queue and then
// the output register. The rate is set by the execute stage, which reads the
// register file, shifts, adds or multiplies and writes back in the same cycle. A
// two-entry queue parts the accepting front from the execute stage, and an output
// register holds each result until it is transferred. Unsupported words produce a
// result with only the unsupported flag and the current flags set.
module arm_integer_execute_unit #(
   parameter int unsigned QUEUE_DEPTH = aieu_pkg::QueueDepth
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_tvalid,
   output logic req_tready,
   input  wire logic [31:0] req_tdata,  // instr_word
   output logic rsp_tvalid,
   input  wire logic rsp_tready,
   // cond_passed, reg_written, dest_index, dest_value, link_written, flags_nzcv,
   // unsupported, zero fill
   output logic [47:0] rsp_tdata
);
   logic q_valid, q_pop;
   aieu_pkg::entry_type q_entry;

   aieu_decode #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_decode (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .q_valid(q_valid), .q_pop(q_pop), .q_entry(q_entry)
   );

   aieu_execute u_execute (
      .clock(clock), .reset(reset),
      .q_valid(q_valid), .q_pop(q_pop), .q_entry(q_entry),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );
endmodule
`default_nettype wire
